/* rtl/mpawm_pkg.sv */
// shared constants and types of the mains peak average window monitor
`timescale 1ns / 1ps

package mpawm_pkg;

    // number of half-period peaks in the averaging window (2 to 64)
    localparam int AVG_DEPTH = 8;

    localparam int SAMPLE_W = 8;
    localparam int THRESH_W = 11;
    localparam int POS_W    = $clog2(AVG_DEPTH);

    // exact window sum, never narrower than the reported field
    localparam int SUM_EXACT_W = $clog2(AVG_DEPTH * 255 + 1);
    localparam int SUM_W       = (SUM_EXACT_W > THRESH_W) ? SUM_EXACT_W : THRESH_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THRESH_W;

    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [THRESH_W-1:0]   t_thresh;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_ZERO_LEVEL      = 2'd0;
    localparam t_cfg_idx CFG_UPPER_THRESHOLD = 2'd1;
    localparam t_cfg_idx CFG_LOWER_THRESHOLD = 2'd2;

    localparam t_sample ZERO_LEVEL_RST      = 8'd128;
    localparam t_thresh UPPER_THRESHOLD_RST = 11'd1800;
    localparam t_thresh LOWER_THRESHOLD_RST = 11'd1400;

    localparam t_thresh PEAK_SUM_MAX = 11'h7FF;

endpackage

/* rtl/mpawm_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mpawm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mains_peak_average_window_monitor.sv */
// top level of the mains peak average window monitor
//
// usage:
//   input channel (i_valid / o_stall) carries one 8-bit adc sample per word.
//   while samples stay above the zero level the positive-half peak is tracked.
//   the first sample at or below the zero level closes the half period: the
//   peak goes into a ring of the last AVG_DEPTH peaks, the window sum is
//   updated and one result word (over, under, ok, peak_sum) is produced.
//   other samples produce no word.
//   output channel (o_valid / i_stall) presents the result from an output
//   register in the cycle after the closing sample is taken.
//   throughput is one sample per cycle while o_stall is low: the ring lives in a
//   ram whose read address always points at the next slot to overwrite, so the
//   old peak is already read out when the closing sample arrives.
//   o_stall rises only while a result is held and the receiver stalls; the
//   held word stays unchanged until taken.
//   config writes (i_cfg_valid / o_cfg_ready) are always taken; index 3 is
//   ignored.
//   reset clears peak, arm flag, ring position, sum and per-slot valid bits,
//   so unwritten ring slots read as zero; no clearing pass is needed.
`timescale 1ns / 1ps

module mains_peak_average_window_monitor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  mpawm_pkg::t_sample   i_sample,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_over_voltage,
    output logic                 o_under_voltage,
    output logic                 o_supply_ok,
    output mpawm_pkg::t_thresh   o_peak_sum,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  mpawm_pkg::t_cfg_idx  i_cfg_index,
    input  mpawm_pkg::t_cfg_data i_cfg_data
);

    import mpawm_pkg::*;

    t_sample              r_zero_level;
    t_thresh              r_upper;
    t_thresh              r_lower;

    t_sample              r_peak;
    logic                 r_armed;
    t_pos                 r_pos;
    t_sum                 r_sum;
    logic [AVG_DEPTH-1:0] r_ring_vld;

    logic                 r_out_vld;
    logic                 r_ov;
    logic                 r_uv;
    logic                 r_ok;
    t_thresh              r_peak_sum;

    t_sample              w_rd_data;
    t_sample              w_old_peak;
    logic                 w_accept;
    logic                 w_high;
    logic                 w_fire;
    t_sum                 n_sum;
    t_pos                 n_pos;
    logic                 n_ov;
    logic                 n_uv;
    t_thresh              n_peak_sum;

    // ring of peaks, read address runs ahead at the slot to replace
    mpawm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_fire),
        .i_wr_addr (r_pos),
        .i_wr_data (r_peak),
        .i_rd_addr (r_pos),
        .o_rd_data (w_rd_data)
    );

    assign o_stall     = r_out_vld && i_stall;
    assign o_cfg_ready = 1'b1;

    assign w_accept = i_valid && !o_stall;
    assign w_high   = i_sample > r_zero_level;
    assign w_fire   = w_accept && !w_high && !r_armed;

    // a boundary never follows a boundary directly, so read data is current
    assign w_old_peak = r_ring_vld[r_pos] ? w_rd_data : '0;

    always_comb begin
        n_sum = r_sum - t_sum'(w_old_peak) + t_sum'(r_peak);
        n_pos = (r_pos == t_pos'(AVG_DEPTH - 1)) ? '0 : r_pos + t_pos'(1);
        n_ov  = n_sum > t_sum'(r_upper);
        n_uv  = n_sum < t_sum'(r_lower);
        if (n_sum > t_sum'(PEAK_SUM_MAX)) begin
            n_peak_sum = PEAK_SUM_MAX;
        end else begin
            n_peak_sum = n_sum[THRESH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_level <= ZERO_LEVEL_RST;
            r_upper      <= UPPER_THRESHOLD_RST;
            r_lower      <= LOWER_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ZERO_LEVEL:      r_zero_level <= i_cfg_data[SAMPLE_W-1:0];
                CFG_UPPER_THRESHOLD: r_upper      <= i_cfg_data;
                CFG_LOWER_THRESHOLD: r_lower      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= '0;
            r_armed    <= 1'b0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_ring_vld <= '0;
        end else if (w_accept) begin
            if (w_high) begin
                if (i_sample > r_peak) begin
                    r_peak <= i_sample;
                end
                r_armed <= 1'b0;
            end else if (!r_armed) begin
                r_armed           <= 1'b1;
                r_peak            <= '0;
                r_sum             <= n_sum;
                r_pos             <= n_pos;
                r_ring_vld[r_pos] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ov       <= n_ov;
            r_uv       <= n_uv;
            r_ok       <= !(n_ov || n_uv);
            r_peak_sum <= n_peak_sum;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_over_voltage  = r_ov;
    assign o_under_voltage = r_uv;
    assign o_supply_ok     = r_ok;
    assign o_peak_sum      = r_peak_sum;

endmodule

/* rtl/mpawm_chk.sv */
// port-level checker of the mains peak average window monitor and its bind
`timescale 1ns / 1ps

module mpawm_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_over_voltage,
    input logic                 o_under_voltage,
    input logic                 o_supply_ok,
    input mpawm_pkg::t_thresh   o_peak_sum
);

    import mpawm_pkg::*;

    // a new result word only follows a taken sample word
    a_rose_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("result word appeared without a taken sample word");

    // ok flag is the complement of both fault flags
    a_ok_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_supply_ok == !(o_over_voltage || o_under_voltage)))
        else $error("supply_ok disagrees with fault flags");

    // input side stalls only while a result word is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result word");

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_peak_sum)
            && $stable(o_over_voltage) && $stable(o_under_voltage)))
        else $error("stalled result word changed");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

endmodule

bind mains_peak_average_window_monitor mpawm_chk u_mpawm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_over_voltage  (o_over_voltage),
    .o_under_voltage (o_under_voltage),
    .o_supply_ok     (o_supply_ok),
    .o_peak_sum      (o_peak_sum)
);

/* tb/sv/testbench.sv */
// self-checking testbench of the mains peak average window monitor
`timescale 1ns / 1ps

module testbench;
    import mpawm_pkg::*;

    localparam t_cfg_idx CFG_UNMAPPED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SENDER_GAP_MAX = 20;
    localparam int STALL_RUN_MAX = 16;

    typedef struct packed {
        logic    over;
        logic    under;
        logic    ok;
        t_thresh peak_sum;
    } t_mains_verdict;

    // tracks the half-period peaks and the window sum, queues the verdicts
    class peak_window_board;
        t_sample        zero_level;
        t_thresh        upper_thr;
        t_thresh        lower_thr;
        t_sample        peak;
        bit             armed;
        t_sample        peaks[AVG_DEPTH];
        int unsigned    slot;
        int unsigned    window_sum;
        t_mains_verdict verdict_q[$];
        int unsigned    mismatches;
        int unsigned    samples_taken;
        int unsigned    verdicts_checked;

        function new();
            zero_level = ZERO_LEVEL_RST;
            upper_thr = UPPER_THRESHOLD_RST;
            lower_thr = LOWER_THRESHOLD_RST;
            peak = '0;
            armed = 1'b0;
            foreach (peaks[i]) peaks[i] = '0;
            slot = 0;
            window_sum = 0;
            mismatches = 0;
            samples_taken = 0;
            verdicts_checked = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_ZERO_LEVEL:      zero_level = data[SAMPLE_W-1:0];
                CFG_UPPER_THRESHOLD: upper_thr = data[THRESH_W-1:0];
                CFG_LOWER_THRESHOLD: lower_thr = data[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample s);
            t_mains_verdict v;
            samples_taken++;
            if (s > zero_level) begin
                if (s > peak) peak = s;
                armed = 1'b0;
            end else if (!armed) begin
                // first low sample closes the half period
                armed = 1'b1;
                window_sum = window_sum - peaks[slot] + peak;
                peaks[slot] = peak;
                slot = (slot + 1) % AVG_DEPTH;
                v.over = window_sum > upper_thr;
                v.under = window_sum < lower_thr;
                v.ok = !(v.over || v.under);
                v.peak_sum = (window_sum > PEAK_SUM_MAX) ? PEAK_SUM_MAX : t_thresh'(window_sum);
                verdict_q.push_back(v);
                peak = '0;
            end
        endfunction

        function void check_result(logic ov, logic uv, logic ok, t_thresh ps);
            t_mains_verdict want;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word over=%0b under=%0b ok=%0b peak_sum=%0d",
                         $time, ov, uv, ok, ps);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            verdicts_checked++;
            if (ov !== want.over) begin
                $display("%0t: over_voltage expected %0b actual %0b", $time, want.over, ov);
                mismatches++;
            end
            if (uv !== want.under) begin
                $display("%0t: under_voltage expected %0b actual %0b", $time, want.under, uv);
                mismatches++;
            end
            if (ok !== want.ok) begin
                $display("%0t: supply_ok expected %0b actual %0b", $time, want.ok, ok);
                mismatches++;
            end
            if (ps !== want.peak_sum) begin
                $display("%0t: peak_sum expected %0d actual %0d", $time, want.peak_sum, ps);
                mismatches++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_sample   i_sample = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    logic      o_over_voltage;
    logic      o_under_voltage;
    logic      o_supply_ok;
    t_thresh   o_peak_sum;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index = '0;
    t_cfg_data i_cfg_data = '0;

    peak_window_board board;
    int sender_pct = 0;
    int stall_pct = 0;
    int stall_run = 0;
    int cycle_count = 0;
    int settings_used = 0;

    mains_peak_average_window_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_over_voltage  (o_over_voltage),
        .o_under_voltage (o_under_voltage),
        .o_supply_ok     (o_supply_ok),
        .o_peak_sum      (o_peak_sum),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, board.pending());
            $display("FAIL mains_peak_average_window_monitor");
            $finish;
        end
    end

    // result side: take words, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                board.check_result(o_over_voltage, o_under_voltage, o_supply_ok, o_peak_sum);
            if (stall_run < STALL_RUN_MAX && $urandom_range(99) < stall_pct) begin
                i_stall <= 1'b1;
                stall_run <= stall_run + 1;
            end else begin
                i_stall <= 1'b0;
                stall_run <= 0;
            end
        end
    end

    task automatic send_sample(input t_sample s);
        int gap;
        gap = 0;
        while (gap < SENDER_GAP_MAX && $urandom_range(99) < sender_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        board.note_sample(s);
    endtask

    task automatic program_regs(input int zl, input int up, input int lo, input bit add_unmapped);
        t_cfg_idx  idx;
        t_cfg_data data;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    idx = CFG_ZERO_LEVEL;
                    // upper data bits must be dropped for the 8-bit register
                    data = t_cfg_data'(zl) | (t_cfg_data'($urandom_range(7)) << SAMPLE_W);
                end
                1: begin
                    idx = CFG_UPPER_THRESHOLD;
                    data = t_cfg_data'(up);
                end
                2: begin
                    idx = CFG_LOWER_THRESHOLD;
                    data = t_cfg_data'(lo);
                end
                default: begin
                    idx = CFG_UNMAPPED;
                    data = t_cfg_data'($urandom_range(2047));
                end
            endcase
            if (k < 3 || add_unmapped) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= idx;
                i_cfg_data <= data;
                do @(posedge i_clk); while (!o_cfg_ready);
                board.write_reg(idx, data);
            end
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        // a closing sample may still sit in the output stage
        repeat (4) @(posedge i_clk);
    endtask

    // mostly clean half periods with random content, some raw noise between them
    task automatic run_wave_phase(input int n);
        int sent, zl, top, hi_len, lo_len;
        sent = 0;
        while (sent < n) begin
            zl = board.zero_level;
            if ($urandom_range(99) < 15) begin
                send_sample(t_sample'($urandom_range(255)));
                sent++;
            end else begin
                hi_len = $urandom_range(6, 1);
                lo_len = $urandom_range(5, 1);
                top = (zl < 255) ? $urandom_range(255, zl + 1) : 255;
                for (int k = 0; k < hi_len; k++)
                    send_sample(t_sample'((zl < 255) ? $urandom_range(top, zl + 1) : 255));
                for (int k = 0; k < lo_len; k++)
                    send_sample(t_sample'($urandom_range(zl, 0)));
                sent += hi_len + lo_len;
            end
        end
    endtask

    initial begin
        int ph_zero[8];
        int ph_upper[8];
        int ph_lower[8];
        int zl, up, lo, mode;

        ph_zero = '{128, 0, 255, 64, 200, -1, -1, -1};
        ph_upper = '{1800, 2047, 0, 1000, 1800, -1, -1, -1};
        ph_lower = '{1400, 0, 2047, 1300, 1700, -1, -1, -1};
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first low sample closes an empty half period,
        // a low sample equal to the zero level closes too, then fill the window
        send_sample(8'd0);
        send_sample(8'd0);
        send_sample(8'd128);
        send_sample(8'd255);
        send_sample(8'd129);
        send_sample(8'd128);
        send_sample(8'd127);
        for (int k = 0; k < 8; k++) begin
            send_sample(8'd255);
            send_sample(8'd0);
        end
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            sender_pct = (mode == 1) ? 72 : (mode == 3) ? 20 : 0;
            stall_pct = (mode == 2) ? 72 : (mode == 3) ? 20 : 0;
            zl = (ph_zero[ph] < 0) ? $urandom_range(200, 80) : ph_zero[ph];
            up = (ph_upper[ph] < 0) ? $urandom_range(2047, 600) : ph_upper[ph];
            lo = (ph_lower[ph] < 0) ? $urandom_range(2047, 600) : ph_lower[ph];
            program_regs(zl, up, lo, ph == 0 || ph == 5);
            // nothing rises above a zero level of 255, so keep that phase short
            run_wave_phase((zl == 255) ? 40 : 195);
            wait_drained();
        end
        repeat (8) @(posedge i_clk);

        $display("%0d samples sent, %0d result words checked, %0d register settings",
                 board.samples_taken, board.verdicts_checked, settings_used);
        $display("idle phases: none, sender gaps, receiver stalls, both; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS mains_peak_average_window_monitor");
        end else begin
            $display("FAIL mains_peak_average_window_monitor");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mpawm_pkg.sv
rtl/mpawm_ram.sv
rtl/mains_peak_average_window_monitor.sv
rtl/mpawm_chk.sv
tb/sv/testbench.sv
